// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file alle_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipping cycles in reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never holds while out of reset
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- hdl/alle_pkg.sv -----
// Shared types and constants of the array linked list engine.
// Depends on nothing; used by the top level, alle_ctrl and alle_checker.
package alle_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 6;
    localparam int LEN_W     = 7;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_INSERT = 3'd1,
        OP_FIND   = 3'd2,
        OP_REMV   = 3'd3,
        OP_REMAT  = 3'd4,
        OP_READ   = 3'd5,
        OP_WRITE  = 3'd6,
        OP_CLEAR  = 3'd7
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
    } cmd_t;

    typedef struct packed {
        logic               ok;
        logic [POS_W-1:0]   found_position;
        logic [VALUE_W-1:0] read_value;
        logic [LEN_W-1:0]   list_length;
    } rsp_t;

endpackage

// ----- hdl/array_linked_list_engine.sv -----
// Channel | dir | fields (low bit first)
// s_axis  | in  | tdata: opcode[2:0] value[34:3] position[40:35]
// m_axis  | out | tdata: ok[0] found_position[6:1] read_value[38:7] list_length[45:39]
//
// One word at a time. Push reads the free head and then links in the new
// entry; insert, remove at, read and write first walk to the position, and
// find and remove by value walk the list comparing each value: one
// next-link RAM read per step of the walk. After reset, and for each clear,
// a sweep over every entry rebuilds the free chain; no word is taken during
// it. A new word is taken while a result waits in the output register.
// Top level of the array linked list engine; depends on alle_pkg and alle_ctrl.
module array_linked_list_engine #(
    parameter int CAPACITY   = alle_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = alle_pkg::DATA_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // opcode, value, position
    input  logic [alle_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // ok, found_position, read_value, list_length
    output logic [alle_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    alle_pkg::cmd_t cmd;
    alle_pkg::rsp_t rsp;
    logic           rsp_valid, rsp_take;
    logic           m_valid_reg, m_valid_next;
    alle_pkg::rsp_t m_data_reg, m_data_next;

    assign cmd.op       = alle_pkg::op_t'(s_axis_tdata[2:0]);
    assign cmd.value    = s_axis_tdata[34:3];
    assign cmd.position = s_axis_tdata[40:35];

    alle_ctrl #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_ctrl (
        .clk(aclk), .rstn(aresetn),
        .cmd_valid(s_axis_tvalid), .cmd(cmd), .cmd_ready(s_axis_tready),
        .rsp_valid(rsp_valid), .rsp(rsp), .rsp_take(rsp_take)
    );

    // Load the output register when it is empty or being drained
    assign rsp_take = rsp_valid && (!m_valid_reg || m_axis_tready);

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (rsp_take) begin
            m_valid_next = 1'b1;
            m_data_next  = rsp;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b0, m_data_reg.list_length, m_data_reg.read_value,
                            m_data_reg.found_position, m_data_reg.ok};

endmodule

// ----- hdl/alle_ram.sv -----
// Single-port synchronous RAM with registered read data.
// Depends on nothing; instantiated by alle_ctrl.
module alle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on request, read the addressed word every cycle
    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/alle_ctrl.sv -----
// Sequencer of the linked list engine: walks and relinks entries held in
// value, next-link and prev-link RAMs. Depends on alle_pkg and alle_ram.
module alle_ctrl #(
    parameter int CAPACITY   = alle_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = alle_pkg::DATA_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rstn,
    input  logic           cmd_valid,
    input  alle_pkg::cmd_t cmd,
    output logic           cmd_ready,
    output logic           rsp_valid,
    output alle_pkg::rsp_t rsp,
    input  logic           rsp_take
);

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int KW = (LW > alle_pkg::POS_W) ? LW : alle_pkg::POS_W;
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);
    localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

    typedef enum logic [15:0] {
        S_SWEEP    = 16'h0001,
        S_IDLE     = 16'h0002,
        S_PUSH_RD  = 16'h0004,
        S_PUSH_WR1 = 16'h0008,
        S_PUSH_WR2 = 16'h0010,
        S_WALK     = 16'h0020,
        S_INS_RD   = 16'h0040,
        S_INS_WR1  = 16'h0080,
        S_INS_WR2  = 16'h0100,
        S_SCAN     = 16'h0200,
        S_UNL_RD   = 16'h0400,
        S_UNL_WR1  = 16'h0800,
        S_UNL_WR2  = 16'h1000,
        S_VAL_RD   = 16'h2000,
        S_VAL_WAIT = 16'h4000,
        S_DONE     = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic [LW-1:0] head_reg, head_next, tail_reg, tail_next, free_reg, free_next;
    logic [LW-1:0] count_reg, count_next;
    logic          boot_reg, boot_next;
    alle_pkg::op_t op_reg, op_next;
    logic [DATA_WIDTH-1:0]       val_reg, val_next;
    logic [alle_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [IW-1:0] cur_reg, cur_next, tgt_reg, tgt_next, cidx_reg, cidx_next;
    logic [IW-1:0] sweep_reg, sweep_next;
    logic [LW-1:0] plink_reg, plink_next;
    logic          first_reg, first_next;
    logic [KW-1:0] kcnt_reg, kcnt_next;
    logic          ok_reg, ok_next;
    logic [alle_pkg::POS_W-1:0]   fpos_reg, fpos_next;
    logic [alle_pkg::VALUE_W-1:0] rval_reg, rval_next;

    // RAM ports
    logic [IW-1:0]         v_addr, n_addr, p_addr;
    logic                  v_we, n_we, p_we;
    logic [DATA_WIDTH-1:0] v_wdata, v_rdata;
    logic [LW-1:0]         n_wdata, n_rdata, p_wdata, p_rdata;

    // Helpers
    logic [63:0]           in_ext, rd_ext;
    logic [IW-1:0]         cur_now;
    logic [KW-1:0]         pos_k, pos_in_k, count_k, kprev;
    logic [15:0]           len_ext;

    alle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
        .clk(clk), .addr(v_addr), .we(v_we), .wdata(v_wdata), .rdata(v_rdata)
    );
    alle_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next_ram (
        .clk(clk), .addr(n_addr), .we(n_we), .wdata(n_wdata), .rdata(n_rdata)
    );
    alle_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev_ram (
        .clk(clk), .addr(p_addr), .we(p_we), .wdata(p_wdata), .rdata(p_rdata)
    );

    assign in_ext   = {32'b0, cmd.value};
    assign rd_ext   = 64'(v_rdata);
    assign cur_now  = first_reg ? cur_reg : n_rdata[IW-1:0];
    assign pos_k    = KW'(pos_reg);
    assign pos_in_k = KW'(cmd.position);
    assign count_k  = KW'(count_reg);
    assign kprev    = kcnt_reg - 1'b1;
    assign len_ext  = 16'(count_reg);

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_DONE);
    assign rsp.ok             = ok_reg;
    assign rsp.found_position = fpos_reg;
    assign rsp.read_value     = rval_reg;
    assign rsp.list_length    = len_ext[alle_pkg::LEN_W-1:0];

    // Next state, list registers and RAM accesses
    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        free_next  = free_reg;
        count_next = count_reg;
        boot_next  = boot_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        pos_next   = pos_reg;
        cur_next   = cur_reg;
        tgt_next   = tgt_reg;
        cidx_next  = cidx_reg;
        sweep_next = sweep_reg;
        plink_next = plink_reg;
        first_next = first_reg;
        kcnt_next  = kcnt_reg;
        ok_next    = ok_reg;
        fpos_next  = fpos_reg;
        rval_next  = rval_reg;
        v_addr = '0; v_we = 1'b0; v_wdata = val_reg;
        n_addr = '0; n_we = 1'b0; n_wdata = '0;
        p_addr = '0; p_we = 1'b0; p_wdata = NIL;

        case (state_reg)
            // Rebuild the free chain one entry a cycle
            S_SWEEP: begin
                n_addr  = sweep_reg;
                n_we    = 1'b1;
                n_wdata = (sweep_reg == LAST) ? NIL : LW'(sweep_reg) + 1'b1;
                p_addr  = sweep_reg;
                p_we    = 1'b1;
                p_wdata = NIL;
                head_next  = NIL;
                tail_next  = NIL;
                free_next  = '0;
                count_next = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST) begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_DONE;
                end
            end
            // Take a word and dispatch
            S_IDLE: begin
                if (cmd_valid) begin
                    op_next    = cmd.op;
                    val_next   = in_ext[DATA_WIDTH-1:0];
                    pos_next   = cmd.position;
                    ok_next    = 1'b0;
                    fpos_next  = '0;
                    rval_next  = '0;
                    cur_next   = head_reg[IW-1:0];
                    first_next = 1'b1;
                    kcnt_next  = '0;
                    state_next = S_DONE;
                    case (cmd.op)
                        alle_pkg::OP_PUSH: begin
                            if (free_reg != NIL) state_next = S_PUSH_RD;
                        end
                        alle_pkg::OP_INSERT: begin
                            if (cmd.position == '0) begin
                                if (free_reg != NIL) state_next = S_PUSH_RD;
                            end else if (free_reg != NIL && pos_in_k < count_k) begin
                                state_next = S_WALK;
                            end
                        end
                        alle_pkg::OP_FIND, alle_pkg::OP_REMV: begin
                            state_next = S_SCAN;
                        end
                        alle_pkg::OP_REMAT, alle_pkg::OP_READ, alle_pkg::OP_WRITE: begin
                            if (pos_in_k < count_k) state_next = S_WALK;
                        end
                        alle_pkg::OP_CLEAR: begin
                            ok_next    = 1'b1;
                            sweep_next = '0;
                            state_next = S_SWEEP;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_PUSH_RD: begin
                n_addr     = free_reg[IW-1:0];
                state_next = S_PUSH_WR1;
            end
            // Fill the taken entry and advance the free head
            S_PUSH_WR1: begin
                cidx_next = free_reg[IW-1:0];
                free_next = n_rdata;
                v_addr = free_reg[IW-1:0]; v_we = 1'b1;
                n_addr = free_reg[IW-1:0]; n_we = 1'b1; n_wdata = head_reg;
                p_addr = free_reg[IW-1:0]; p_we = 1'b1; p_wdata = NIL;
                state_next = S_PUSH_WR2;
            end
            S_PUSH_WR2: begin
                if (head_reg != NIL) begin
                    p_addr  = head_reg[IW-1:0];
                    p_we    = 1'b1;
                    p_wdata = LW'(cidx_reg);
                end else begin
                    tail_next = LW'(cidx_reg);
                end
                head_next  = LW'(cidx_reg);
                count_next = count_reg + 1'b1;
                ok_next    = 1'b1;
                state_next = S_DONE;
            end
            // Follow next links, one per cycle, to the target position
            S_WALK: begin
                if (kcnt_reg == pos_k) begin
                    tgt_next = cur_now;
                    case (op_reg)
                        alle_pkg::OP_INSERT: state_next = S_INS_RD;
                        alle_pkg::OP_REMAT: begin
                            ok_next    = 1'b1;
                            fpos_next  = pos_reg;
                            state_next = S_UNL_RD;
                        end
                        alle_pkg::OP_READ: begin
                            ok_next    = 1'b1;
                            fpos_next  = pos_reg;
                            state_next = S_VAL_RD;
                        end
                        default: begin
                            v_addr     = cur_now;
                            v_we       = 1'b1;
                            ok_next    = 1'b1;
                            fpos_next  = pos_reg;
                            state_next = S_DONE;
                        end
                    endcase
                end else begin
                    n_addr     = cur_now;
                    cur_next   = cur_now;
                    kcnt_next  = kcnt_reg + 1'b1;
                    first_next = 1'b0;
                end
            end
            S_INS_RD: begin
                p_addr     = tgt_reg;
                n_addr     = free_reg[IW-1:0];
                state_next = S_INS_WR1;
            end
            // Fill the new entry between its neighbours
            S_INS_WR1: begin
                cidx_next  = free_reg[IW-1:0];
                plink_next = p_rdata;
                free_next  = n_rdata;
                v_addr = free_reg[IW-1:0]; v_we = 1'b1;
                n_addr = free_reg[IW-1:0]; n_we = 1'b1; n_wdata = LW'(tgt_reg);
                p_addr = free_reg[IW-1:0]; p_we = 1'b1; p_wdata = p_rdata;
                state_next = S_INS_WR2;
            end
            S_INS_WR2: begin
                n_addr = plink_reg[IW-1:0]; n_we = 1'b1; n_wdata = LW'(cidx_reg);
                p_addr = tgt_reg;           p_we = 1'b1; p_wdata = LW'(cidx_reg);
                count_next = count_reg + 1'b1;
                ok_next    = 1'b1;
                fpos_next  = pos_reg;
                state_next = S_DONE;
            end
            // Compare each value read against the key while fetching the next
            S_SCAN: begin
                if (!first_reg && v_rdata == val_reg) begin
                    ok_next    = 1'b1;
                    fpos_next  = kprev[alle_pkg::POS_W-1:0];
                    tgt_next   = cur_reg;
                    state_next = (op_reg == alle_pkg::OP_REMV) ? S_UNL_RD : S_DONE;
                end else if (kcnt_reg == count_k) begin
                    state_next = S_DONE;
                end else begin
                    n_addr     = cur_now;
                    v_addr     = cur_now;
                    cur_next   = cur_now;
                    kcnt_next  = kcnt_reg + 1'b1;
                    first_next = 1'b0;
                end
            end
            S_UNL_RD: begin
                p_addr     = tgt_reg;
                n_addr     = tgt_reg;
                state_next = S_UNL_WR1;
            end
            // Bridge the neighbours of the removed entry
            S_UNL_WR1: begin
                if (p_rdata != NIL) begin
                    n_addr = p_rdata[IW-1:0]; n_we = 1'b1; n_wdata = n_rdata;
                end else begin
                    head_next = n_rdata;
                end
                if (n_rdata != NIL) begin
                    p_addr = n_rdata[IW-1:0]; p_we = 1'b1; p_wdata = p_rdata;
                end else begin
                    tail_next = p_rdata;
                end
                state_next = S_UNL_WR2;
            end
            // Hand the entry back to the free chain
            S_UNL_WR2: begin
                n_addr = tgt_reg; n_we = 1'b1; n_wdata = free_reg;
                free_next  = LW'(tgt_reg);
                count_next = count_reg - 1'b1;
                state_next = S_DONE;
            end
            S_VAL_RD: begin
                v_addr     = tgt_reg;
                state_next = S_VAL_WAIT;
            end
            S_VAL_WAIT: begin
                rval_next  = rd_ext[alle_pkg::VALUE_W-1:0];
                state_next = S_DONE;
            end
            // Hold the result until the output stage takes it
            S_DONE: begin
                if (rsp_take) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= S_SWEEP;
            boot_reg  <= 1'b1;
            sweep_reg <= '0;
            head_reg  <= NIL;
            tail_reg  <= NIL;
            free_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            boot_reg  <= boot_next;
            sweep_reg <= sweep_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            free_reg  <= free_next;
            count_reg <= count_next;
        end
    end

    // Working and result registers
    always_ff @(posedge clk) begin
        op_reg    <= op_next;
        val_reg   <= val_next;
        pos_reg   <= pos_next;
        cur_reg   <= cur_next;
        tgt_reg   <= tgt_next;
        cidx_reg  <= cidx_next;
        plink_reg <= plink_next;
        first_reg <= first_next;
        kcnt_reg  <= kcnt_next;
        ok_reg    <= ok_next;
        fpos_reg  <= fpos_next;
        rval_reg  <= rval_next;
    end

endmodule

// ----- hdl/alle_checker.sv -----
// Port-level checks of the array linked list engine, bound to the top level.
// Depends on alle_pkg and assert_macros.svh.
`include "assert_macros.svh"

module alle_checker #(
    parameter int CAPACITY = alle_pkg::CAPACITY_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [alle_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result stays offered
    `ASSERT_CLK(a_hold_valid, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result word dropped while stalled")

    // Count never exceeds the store
    `ASSERT_CLK(a_len_cap, aclk, aresetn, m_axis_tvalid |-> m_axis_tdata[45:39] <= CAPACITY, "list length beyond capacity")

    // A failure reports position zero
    `ASSERT_NEVER(a_fail_pos, aclk, aresetn, m_axis_tvalid && !m_axis_tdata[0] && m_axis_tdata[6:1] != 6'd0, "failed word carries a position")

    // Data comes back only from a successful read
    `ASSERT_NEVER(a_fail_val, aclk, aresetn, m_axis_tvalid && !m_axis_tdata[0] && m_axis_tdata[38:7] != 32'd0, "failed word carries data")

endmodule

bind array_linked_list_engine alle_checker #(.CAPACITY(CAPACITY)) u_alle_checker (.*);
